FILE: sv/ieb_pkg.sv
// ----------------------------------------------------------------------------
// ieb_pkg: shared types and codes of the insertable element buffer
// Operation and status codes, stream field widths and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package ieb_pkg;

  localparam int KIND_W     = 3;
  localparam int INDEX_W    = 4;
  localparam int VALUE_W    = 32;
  localparam int READ_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_PUSH   = 3'd0;
  localparam kind_t KIND_POP    = 3'd1;
  localparam kind_t KIND_INSERT = 3'd2;
  localparam kind_t KIND_READ   = 3'd3;
  localparam kind_t KIND_WRITE  = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  // Broadcast to every cell in a cycle.
  typedef struct packed {
    logic load;   // the cell at the load position takes the new word
    logic shift;  // cells above the load position take their lower neighbor
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/ieb_cell.sv
// ----------------------------------------------------------------------------
// ieb_cell: one storage slot of the buffer chain
// Holds one word; loads the new word or takes the lower neighbor's word.
// ----------------------------------------------------------------------------
`default_nettype none

module ieb_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int POS_W      = 4,
  parameter int SLOT       = 0
) (
  input  wire                       clk,
  input  ieb_pkg::cell_ctl_t        ctl,
  input  wire  [POS_W-1:0]          pos,
  input  wire  [DATA_WIDTH-1:0]     word,
  input  wire  [DATA_WIDTH-1:0]     prev_word,
  output logic [DATA_WIDTH-1:0]     word_q
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(SLOT);

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load && (pos == MY_POS)) begin
      entry_nxt = word;
    end else if (ctl.shift && (MY_POS > pos)) begin
      entry_nxt = prev_word;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign word_q = entry_r;

endmodule

`default_nettype wire

FILE: sv/insertable_element_buffer.sv
// ----------------------------------------------------------------------------
// insertable_element_buffer: ordered buffer of signed words with insert
// An ordered buffer of up to DEPTH signed words that takes one request per
// clock cycle: push, pop, insert at an index (later entries move up by one),
// read or write at an index. Storage is a chain of DEPTH cells; in the cycle a
// request is accepted the cells update at once, each loading the new word,
// taking its lower neighbor's word or holding, so the cost of a request does
// not depend on where it lands. Each request gives one result, in the cycle
// after it is accepted, from the output register: the word read (zero unless a
// successful read), the count after the request and a status (ok, full, empty
// pop, index out of range). A result held by a stalled receiver blocks the
// request channel; the next request is taken in the same cycle the held
// result drains, so the sustained rate is one request per cycle while
// out_tready stays high. Refused requests leave the buffer unchanged. Only
// the first 16 slots are reachable by index; a popped slot is not cleared, as
// it reads again only after a later write.
// ----------------------------------------------------------------------------
`default_nettype none

module insertable_element_buffer #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // [3:0] index, [35:4] value, [39:36] zero
  input  wire  [2:0]  in_tuser,   // [2:0] kind
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] read_value, [36:32] count, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int POS_W  = $clog2(DEPTH);
  // compare width wide enough for both the fill level and the index field
  localparam int CMP_W  = (FILL_W > ieb_pkg::INDEX_W) ? FILL_W : ieb_pkg::INDEX_W + 1;
  // slots the index field can reach
  localparam int NREAD  = (DEPTH < 16) ? DEPTH : 16;

  // --------------------------------------------------------------------------
  // Request fields
  // --------------------------------------------------------------------------
  ieb_pkg::kind_t             req_kind;
  logic [ieb_pkg::INDEX_W-1:0] req_index;
  logic signed [ieb_pkg::VALUE_W-1:0] req_value;
  logic signed [DATA_WIDTH-1:0] req_word;

  assign req_kind  = in_tuser[2:0];
  assign req_index = in_tdata[3:0];
  assign req_value = in_tdata[35:4];
  // sign-extend or cut the value to the stored width as two's complement
  assign req_word  = DATA_WIDTH'(req_value);

  // --------------------------------------------------------------------------
  // State and handshake
  // --------------------------------------------------------------------------
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              out_valid_r;
  logic [ieb_pkg::READ_W-1:0]   out_read_r;
  logic [ieb_pkg::COUNT_W-1:0]  out_count_r;
  ieb_pkg::status_t             out_status_r;
  logic              accept;

  // take a request whenever the result slot is free or drains this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Cell chain
  // --------------------------------------------------------------------------
  logic [DATA_WIDTH-1:0] chain_w [DEPTH+1];
  ieb_pkg::cell_ctl_t    cell_ctl;
  ieb_pkg::cell_ctl_t    dec_ctl;
  logic [POS_W-1:0]      dec_pos;

  assign chain_w[0] = '0;

  // hold every cell unless a request is accepted
  assign cell_ctl.load  = dec_ctl.load && accept;
  assign cell_ctl.shift = dec_ctl.shift && accept;

  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_cell
    ieb_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .POS_W      (POS_W),
      .SLOT       (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .pos       (dec_pos),
      .word      (req_word),
      .prev_word (chain_w[g]),
      .word_q    (chain_w[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Read port: select one of the slots the index field reaches
  // --------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] rd_word;

  always_comb begin
    rd_word = '0;
    for (int j = 0; j < NREAD; j++) begin
      if (req_index == ieb_pkg::INDEX_W'(j)) begin
        rd_word = chain_w[j+1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0]           fill_c;
  logic [CMP_W-1:0]           index_c;
  logic                       is_full;
  ieb_pkg::status_t           dec_status;
  logic [ieb_pkg::READ_W-1:0] dec_read;

  assign fill_c  = CMP_W'(fill_r);
  assign index_c = CMP_W'(req_index);
  assign is_full = (fill_r == FILL_W'(DEPTH));

  always_comb begin
    dec_ctl    = '0;
    dec_pos    = POS_W'(fill_r);
    dec_status = ieb_pkg::ST_OK;
    dec_read   = '0;
    fill_nxt   = fill_r;
    unique case (req_kind)
      ieb_pkg::KIND_PUSH: begin
        if (is_full) begin
          dec_status = ieb_pkg::ST_FULL;
        end else begin
          dec_ctl.load = 1'b1;
          fill_nxt     = fill_r + FILL_W'(1);
        end
      end
      ieb_pkg::KIND_POP: begin
        if (fill_r == '0) begin
          dec_status = ieb_pkg::ST_EMPTY;
        end else begin
          fill_nxt = fill_r - FILL_W'(1);
        end
      end
      ieb_pkg::KIND_INSERT: begin
        dec_pos = POS_W'(req_index);
        if (is_full) begin
          dec_status = ieb_pkg::ST_FULL;
        end else if (index_c > fill_c) begin
          dec_status = ieb_pkg::ST_RANGE;
        end else begin
          dec_ctl.load  = 1'b1;
          dec_ctl.shift = 1'b1;
          fill_nxt      = fill_r + FILL_W'(1);
        end
      end
      ieb_pkg::KIND_READ: begin
        if (index_c >= fill_c) begin
          dec_status = ieb_pkg::ST_RANGE;
        end else begin
          // sign-extend or cut the stored word to the result width
          dec_read = ieb_pkg::READ_W'(rd_word);
        end
      end
      ieb_pkg::KIND_WRITE: begin
        dec_pos = POS_W'(req_index);
        if (index_c >= fill_c) begin
          dec_status = ieb_pkg::ST_RANGE;
        end else begin
          dec_ctl.load = 1'b1;
        end
      end
      default: begin
        // unused codes: no operation
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Fill level and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_r   <= dec_read;
      out_count_r  <= ieb_pkg::COUNT_W'(fill_nxt);
      out_status_r <= dec_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_read_r};
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("fill level beyond capacity");

  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (dec_status != ieb_pkg::ST_OK) |=> $stable(fill_r))
    else $error("refused request changed the fill level");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ieb_pkg::ST_FULL)
      |-> (out_tdata[36:32] == ieb_pkg::COUNT_W'(DEPTH)))
    else $error("full status without a full count");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ieb_pkg::ST_EMPTY) |-> (out_tdata[36:32] == '0))
    else $error("empty status with a nonzero count");
`endif

endmodule

`default_nettype wire
